>>> hdl/ile_pkg.sv
// Package with the shared sizes, codes and cell command type of the indexed list engine.
package ile_pkg;

    localparam int ILE_DEPTH = 16;
    localparam int ILE_WIDTH = 32;
    localparam int IDX_W     = $clog2(ILE_DEPTH);
    localparam int CNT_W     = $clog2(ILE_DEPTH + 1);
    localparam int POS_W     = 5;
    localparam int OPC_W     = 4;
    localparam int STAT_W    = 2;

    typedef enum logic [OPC_W-1:0] {
        OP_INS_HEAD = 4'd0,
        OP_INS_TAIL = 4'd1,
        OP_INS_AT   = 4'd2,
        OP_DEL_HEAD = 4'd3,
        OP_DEL_TAIL = 4'd4,
        OP_DEL_AT   = 4'd5,
        OP_READ     = 4'd6,
        OP_WRITE    = 4'd7,
        OP_CLEAR    = 4'd8
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [IDX_W-1:0]     pos;
        logic [ILE_WIDTH-1:0] value;
    } t_cell_cmd;

endpackage

>>> hdl/indexed_list_engine_core.sv
// Top level of the indexed list engine: opcode decode, cell chain and result register.
//
// Usage: each transaction on the slave stream (s_axis_*) carries one list
// operation: an opcode, a position and a value. Every accepted transaction
// produces exactly one result transaction on the master stream (m_axis_*)
// with a status, the read value (zero unless a read succeeds), the element
// count after the operation and an empty flag.
// The list lives in a chain of identical cells, one element per cell. An
// insert or delete moves every affected element to its neighbor cell in the
// same clock. The result is registered and becomes valid in the cycle after
// the input is accepted. Throughput is one operation per cycle while the
// receiver keeps tready high; the result is held in a single register.
// A new transaction is taken while the previous result is being taken, so
// input and output overlap fully when the receiver keeps tready high.
// When the receiver stalls, the pending result holds and s_axis_tready
// drops until the result register is free.
// Reset (i_rst_n low, synchronous) empties the list and drops the result
// valid; the cell contents are not cleared, since entries at or beyond the
// count are never returned.
module indexed_list_engine_core
    import ile_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] opcode, [8:4] position, [40:9] write_value, [47:41] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [33:2] read_value, [38:34] element_count, [39] is_empty
    output logic [39:0] m_axis_tdata
);

    logic [OPC_W-1:0]     w_opcode;
    logic [POS_W-1:0]     w_pos;
    logic [ILE_WIDTH-1:0] w_value;

    assign w_opcode = s_axis_tdata[3:0];
    assign w_pos    = s_axis_tdata[8:4];
    assign w_value  = s_axis_tdata[40:9];

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [ILE_WIDTH-1:0] r_out_read;
    logic [CNT_W-1:0]     r_out_count;

    t_status              w_status;
    logic [ILE_WIDTH-1:0] w_read;
    t_cell_cmd            w_cmd;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_pos_lt;
    logic                 w_pos_le;
    logic [CNT_W-1:0]     w_pos_ext;

    logic [ILE_WIDTH-1:0] w_cell_data [ILE_DEPTH];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_pos_ext = CNT_W'(w_pos);
    assign w_full    = (r_count == CNT_W'(ILE_DEPTH));
    assign w_pos_lt  = (w_pos_ext < r_count) && (w_pos < POS_W'(ILE_DEPTH));
    assign w_pos_le  = (w_pos_ext <= r_count) && (w_pos <= POS_W'(ILE_DEPTH));

    // Decode: status, the count after the operation and the command
    // broadcast to all cells. Cells only change state on an accepted item.
    always_comb begin
        w_status    = ST_OK;
        w_read      = '0;
        n_count     = r_count;
        w_cmd.kind  = CMD_HOLD;
        w_cmd.pos   = w_pos[IDX_W-1:0];
        w_cmd.value = w_value;
        case (w_opcode)
            OP_INS_HEAD: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.kind = CMD_OPEN;
                    w_cmd.pos  = '0;
                    n_count    = r_count + 1'b1;
                end
            end
            OP_INS_TAIL: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.kind = CMD_OPEN;
                    w_cmd.pos  = r_count[IDX_W-1:0];
                    n_count    = r_count + 1'b1;
                end
            end
            OP_INS_AT: begin
                if (!w_pos_le) begin
                    w_status = ST_RANGE;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cmd.kind = CMD_OPEN;
                    n_count    = r_count + 1'b1;
                end
            end
            OP_DEL_HEAD: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cmd.kind = CMD_CLOSE;
                    w_cmd.pos  = '0;
                    n_count    = r_count - 1'b1;
                end
            end
            OP_DEL_TAIL: begin
                // The tail element simply falls out of the counted range.
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_DEL_AT: begin
                if (!w_pos_lt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_cmd.kind = CMD_CLOSE;
                    n_count    = r_count - 1'b1;
                end
            end
            OP_READ: begin
                if (!w_pos_lt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_read = w_cell_data[w_pos[IDX_W-1:0]];
                end
            end
            OP_WRITE: begin
                if (!w_pos_lt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_cmd.kind = CMD_WRITE;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                // Unused opcodes leave the list alone and report ok.
                w_status = ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_cmd.kind = CMD_HOLD;
        end
    end

    // The cell chain. The first cell has no left neighbor and the last has
    // no right neighbor; those inputs are never selected in a way that
    // reaches a counted element.
    for (genvar g = 0; g < ILE_DEPTH; g++) begin : g_cell
        logic [ILE_WIDTH-1:0] w_left;
        logic [ILE_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_value;
        end else begin : g_mid_l
            assign w_left = w_cell_data[g-1];
        end
        if (g == ILE_DEPTH - 1) begin : g_last
            assign w_right = w_cell_data[g];
        end else begin : g_mid_r
            assign w_right = w_cell_data[g+1];
        end
        ile_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_cell_data[g])
        );
    end

    // Control state and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_status <= w_status;
            r_out_read   <= w_read;
            r_out_count  <= n_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(r_out_count == '0), r_out_count, r_out_read, r_out_status};

    // The count never runs past the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ILE_DEPTH))
        else $error("element count exceeds list depth");

    // A pending result always reports the live count.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count == r_count))
        else $error("result count differs from list count");

    // A full status is only reported against a full list.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_FULL) |-> (r_count == CNT_W'(ILE_DEPTH)))
        else $error("full status on a list that is not full");

    // An empty status is only reported against an empty list.
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status on a list that is not empty");

endmodule

>>> hdl/ile_cell.sv
// One storage cell of the list chain: holds one element and trades it with its neighbors.
module ile_cell
    import ile_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_cmd            i_cmd,
    input  logic [IDX_W-1:0]     i_index,
    input  logic [ILE_WIDTH-1:0] i_left,
    input  logic [ILE_WIDTH-1:0] i_right,
    output logic [ILE_WIDTH-1:0] o_data
);

    logic [ILE_WIDTH-1:0] r_data;
    logic [ILE_WIDTH-1:0] n_data;

    // Behind the opened slot every cell takes its left neighbor; at or behind
    // a closed slot every cell takes its right neighbor.
    always_comb begin
        n_data = r_data;
        case (i_cmd.kind)
            CMD_OPEN: begin
                if (i_index == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end else if (i_index > i_cmd.pos) begin
                    n_data = i_left;
                end
            end
            CMD_CLOSE: begin
                if (i_index >= i_cmd.pos) begin
                    n_data = i_right;
                end
            end
            CMD_WRITE: begin
                if (i_index == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

>>> bench/tb_indexed_list_engine_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the indexed list engine core, with a list scoreboard and stream drivers.
module tb_indexed_list_engine_core
    import ile_pkg::*;
();

    // Only the first few mismatches are printed in full; later ones are just counted.
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_OPS  = 1400;
    localparam int NUM_PHASES  = 3;

    // One result transaction, split into its fields.
    typedef struct {
        t_status              status;
        logic [ILE_WIDTH-1:0] read_value;
        logic [4:0]           element_count;
        logic                 is_empty;
    } t_list_result;

    // The scoreboard keeps its own copy of the list. Each accepted operation
    // is applied to that copy at once, and the result it must produce is queued.
    class t_list_scoreboard;
        logic [ILE_WIDTH-1:0] words [ILE_DEPTH];
        int unsigned          count;
        t_list_result         expected_q [$];
        int                   errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Makes room at index pos by moving the elements behind it one step up.
        function void open_slot(int unsigned pos, logic [ILE_WIDTH-1:0] value);
            for (int unsigned i = count; i > pos; i--) begin
                words[i] = words[i-1];
            end
            words[pos] = value;
            count++;
        endfunction

        // Removes the element at index pos by moving the ones behind it down.
        function void close_slot(int unsigned pos);
            for (int unsigned i = pos; i + 1 < count; i++) begin
                words[i] = words[i+1];
            end
            count--;
        endfunction

        function void note_op(logic [OPC_W-1:0] op, logic [POS_W-1:0] pos,
                              logic [ILE_WIDTH-1:0] value);
            t_list_result res;
            res.status     = ST_OK;
            res.read_value = '0;
            case (op)
                OP_INS_HEAD: begin
                    if (count >= ILE_DEPTH) res.status = ST_FULL;
                    else open_slot(0, value);
                end
                OP_INS_TAIL: begin
                    if (count >= ILE_DEPTH) res.status = ST_FULL;
                    else open_slot(count, value);
                end
                OP_INS_AT: begin
                    // A bad position is reported ahead of a full list.
                    if (pos > count) res.status = ST_RANGE;
                    else if (count >= ILE_DEPTH) res.status = ST_FULL;
                    else open_slot(pos, value);
                end
                OP_DEL_HEAD: begin
                    if (count == 0) res.status = ST_EMPTY;
                    else close_slot(0);
                end
                OP_DEL_TAIL: begin
                    if (count == 0) res.status = ST_EMPTY;
                    else close_slot(count - 1);
                end
                OP_DEL_AT: begin
                    if (pos >= count) res.status = ST_RANGE;
                    else close_slot(pos);
                end
                OP_READ: begin
                    if (pos >= count) res.status = ST_RANGE;
                    else res.read_value = words[pos];
                end
                OP_WRITE: begin
                    if (pos >= count) res.status = ST_RANGE;
                    else words[pos] = value;
                end
                OP_CLEAR: begin
                    count = 0;
                end
                default: begin
                    // Undefined opcodes leave the list alone and report ok.
                end
            endcase
            res.element_count = count[4:0];
            res.is_empty      = (count == 0);
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [39:0] data);
            t_list_result act;
            t_list_result exp;
            act.status        = t_status'(data[1:0]);
            act.read_value    = data[33:2];
            act.element_count = data[38:34];
            act.is_empty      = data[39];
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: status %0d value %h count %0d",
                             $realtime, act.status, act.read_value, act.element_count);
                return;
            end
            exp = expected_q.pop_front();
            if (act.status !== exp.status || act.read_value !== exp.read_value ||
                act.element_count !== exp.element_count || act.is_empty !== exp.is_empty) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $write("%0t: wrong result (expected/actual): ", $realtime);
                    $display("status %0d/%0d value %h/%h count %0d/%0d empty %b/%b",
                             exp.status, act.status, exp.read_value, act.read_value,
                             exp.element_count, act.element_count, exp.is_empty, act.is_empty);
                end
            end
        endfunction

        function bit clean();
            return (errors == 0) && (expected_q.size() == 0);
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [3:0] opcode, [8:4] position, [40:9] write_value, [47:41] zero
    logic [47:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [1:0] status, [33:2] read_value, [38:34] element_count, [39] is_empty
    logic [39:0] m_axis_tdata;

    t_list_scoreboard sb = new();

    // Percent of cycles in which each side idles; changed per phase.
    int send_idle_pct = 23;
    int recv_idle_pct = 82;
    // Cycles left in a forced receiver hold-off.
    int stall_left    = 0;
    // Bias of the random traffic: 0 grows the list, 1 shrinks it, 2 mixes.
    int burst_mode    = 2;

    indexed_list_engine_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver either serves a forced hold-off, counted down here, or
    // stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Every result transaction is checked against the oldest expectation.
    // Values are sampled just after the edge, before any update at that edge lands.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Offers one operation, after a random number of idle cycles, and holds it
    // until the block takes it. The accepted transaction goes to the scoreboard.
    task automatic send_op(input logic [OPC_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [ILE_WIDTH-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, value, pos, op};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_op(op, pos, value);
    endtask

    // Draws one random operation. The mix leans on the current burst mode so
    // that the list runs both full and empty, and positions mostly land near
    // the valid range with an occasional wild index.
    task automatic pick_op(output logic [OPC_W-1:0] op, output logic [POS_W-1:0] pos,
                           output logic [ILE_WIDTH-1:0] value);
        int roll;
        int ins_w;
        int del_w;
        ins_w = (burst_mode == 0) ? 60 : (burst_mode == 1) ? 15 : 35;
        del_w = (burst_mode == 0) ? 15 : (burst_mode == 1) ? 60 : 30;
        roll  = $urandom_range(0, 99);
        if (roll < 3) begin
            op = 4'($urandom_range(9, 15));
        end else if (roll < 5) begin
            op = OP_CLEAR;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < ins_w) begin
                case ($urandom_range(0, 2))
                    0: op = OP_INS_HEAD;
                    1: op = OP_INS_TAIL;
                    default: op = OP_INS_AT;
                endcase
            end else if (roll < ins_w + del_w) begin
                case ($urandom_range(0, 2))
                    0: op = OP_DEL_HEAD;
                    1: op = OP_DEL_TAIL;
                    default: op = OP_DEL_AT;
                endcase
            end else begin
                op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
            end
        end
        if ($urandom_range(0, 99) < 80)
            pos = 5'($urandom_range(0, sb.count));
        else
            pos = 5'($urandom_range(0, 31));
        case ($urandom_range(0, 19))
            0: value = 32'h8000_0000;
            1: value = 32'h7FFF_FFFF;
            2: value = 32'hFFFF_FFFF;
            3: value = 32'h0000_0000;
            default: value = $urandom;
        endcase
    endtask

    initial begin
        logic [OPC_W-1:0]     op;
        logic [POS_W-1:0]     pos;
        logic [ILE_WIDTH-1:0] value;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: the empty and range errors on an empty list, inserts at
        // both ends and in the middle with extreme values, reads across the
        // list and past it, a write, deletes, undefined opcodes and clears.
        send_op(OP_DEL_HEAD, 5'd0, '0);
        send_op(OP_DEL_TAIL, 5'd0, '0);
        send_op(OP_DEL_AT,   5'd0, '0);
        send_op(OP_READ,     5'd0, '0);
        send_op(OP_WRITE,    5'd0, 32'h1234_5678);
        send_op(OP_INS_AT,   5'd1, 32'h1111_1111);
        send_op(OP_INS_HEAD, 5'd0, 32'h7FFF_FFFF);
        send_op(OP_INS_TAIL, 5'd0, 32'h8000_0000);
        send_op(OP_INS_AT,   5'd1, 32'hFFFF_FFFF);
        send_op(OP_INS_AT,   5'd3, 32'h0000_0000);
        for (int i = 0; i < 5; i++)
            send_op(OP_READ, 5'(i), '0);
        send_op(OP_WRITE,    5'd2, 32'h5A5A_5A5A);
        send_op(OP_READ,     5'd31, '0);
        send_op(OP_DEL_AT,   5'd1, '0);
        send_op(4'd9,        5'd0, 32'hFFFF_FFFF);
        send_op(4'd15,       5'd31, 32'hFFFF_FFFF);
        send_op(OP_DEL_TAIL, 5'd0, '0);
        send_op(OP_READ,     5'd1, '0);
        send_op(OP_CLEAR,    5'd0, '0);
        send_op(OP_CLEAR,    5'd0, '0);
        send_op(OP_READ,     5'd0, '0);

        // Random traffic in three phases: a slow receiver, then a slow
        // sender, then full rate on both sides.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 82;
                recv_idle_pct = 23;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // Hold the receiver off for a long stretch while items keep
                // coming, so the result register backs up into the input.
                stall_left = 120;
            end
            for (int n = 0; n < RANDOM_OPS / NUM_PHASES; n++) begin
                if (n % 40 == 0)
                    burst_mode = $urandom_range(0, 2);
                pick_op(op, pos, value);
                send_op(op, pos, value);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        // A few more cycles so a stray extra result would still be caught.
        repeat (10) @(posedge i_clk);

        if (sb.clean())
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this time.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ile_pkg.sv
hdl/ile_cell.sv
hdl/indexed_list_engine_core.sv
bench/tb_indexed_list_engine_core.sv
